// File: rtl/lob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;
    localparam int MAX_ORDERS = 64;
    localparam int IDX_W      = $clog2(MAX_ORDERS);
    localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
    localparam int PRICE_W    = 30;
    localparam int AGENT_W    = 8;
    localparam int QTY_W      = 32;
    localparam int ID_W       = 32;
    localparam int FEE_W      = 16;
    localparam int FEE_TOT_W  = 22;

    localparam logic [PRICE_W-1:0] PRICE_TOP = PRICE_W'(999999999);
    localparam logic [PRICE_W-1:0] NO_ASK    = PRICE_W'(1000000000);
    localparam logic [ID_W-1:0]    ID_END    = '1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_MARKET = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_IDS_OUT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    // one resting order; side 1 is a bid
    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [AGENT_W-1:0] agent;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
    } t_row;

    typedef struct packed {
        logic               is_buy;
        logic [AGENT_W-1:0] agent;
        logic [ID_W-1:0]    cid;
        logic               clr_en;
    } t_scan_ctx;

    typedef struct packed {
        logic [PRICE_W-1:0] best_bid;
        logic [PRICE_W-1:0] best_ask;
        logic               pick_found;
        logic [IDX_W-1:0]   pick_idx;
        t_row               pick_row;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               match_found;
        logic [IDX_W-1:0]   match_idx;
        logic [CNT_W-1:0]   clr_count;
    } t_scan_res;
endpackage
`default_nettype wire

// File: rtl/lob_store.sv
`timescale 1ns / 1ps
`default_nettype none
module lob_store (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [lob_pkg::IDX_W-1:0] i_rd_addr,
    input  wire logic                    i_wr_en,
    input  wire logic [lob_pkg::IDX_W-1:0] i_wr_addr,
    input  wire lob_pkg::t_row           i_wr_row,
    input  wire logic                    i_inv_en,
    input  wire logic [lob_pkg::IDX_W-1:0] i_inv_addr,
    output lob_pkg::t_row                o_rd_row,
    output logic                         o_rd_valid
);
    import lob_pkg::*;

    t_row                  r_mem [MAX_ORDERS];
    logic [MAX_ORDERS-1:0] r_valid;
    t_row                  r_rd_row;
    logic                  r_rd_valid;

    // valid bits: set on write, cleared on invalidate (invalidate wins)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_inv_en) begin
                r_valid[i_inv_addr] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        r_rd_row <= r_mem[i_rd_addr];
    end

    assign o_rd_row   = r_rd_row;
    assign o_rd_valid = r_rd_valid;
endmodule
`default_nettype wire

// File: rtl/lob_scan.sv
`timescale 1ns / 1ps
`default_nettype none
module lob_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_init,
    input  wire logic                      i_stage_v,
    input  wire logic [lob_pkg::IDX_W-1:0] i_stage_idx,
    input  wire lob_pkg::t_row             i_row,
    input  wire logic                      i_row_valid,
    input  wire lob_pkg::t_scan_ctx        i_ctx,
    output lob_pkg::t_scan_res             o_res,
    output logic                           o_clr_hit
);
    import lob_pkg::*;

    t_scan_res r_res;
    t_scan_res n_res;
    logic      vld;
    logic      live;
    logic      clr_hit;
    logic      eligible;
    logic      better;

    always_comb begin
        vld      = i_stage_v & i_row_valid;
        clr_hit  = vld & i_ctx.clr_en & (i_row.agent == i_ctx.agent);
        live     = vld & ~clr_hit;
        eligible = live & (i_row.agent != i_ctx.agent) & (i_row.side != i_ctx.is_buy);
        // price first, then older id
        if (i_row.price != r_res.pick_row.price) begin
            better = i_ctx.is_buy ? (i_row.price < r_res.pick_row.price)
                                  : (i_row.price > r_res.pick_row.price);
        end else begin
            better = i_row.id < r_res.pick_row.id;
        end

        n_res = r_res;
        if (i_init) begin
            n_res             = '0;
            n_res.best_ask    = NO_ASK;
        end else if (i_stage_v) begin
            if (live && i_row.side && (i_row.price > r_res.best_bid)) begin
                n_res.best_bid = i_row.price;
            end
            if (live && !i_row.side && (i_row.price < r_res.best_ask)) begin
                n_res.best_ask = i_row.price;
            end
            if (eligible && (!r_res.pick_found || better)) begin
                n_res.pick_found = 1'b1;
                n_res.pick_idx   = i_stage_idx;
                n_res.pick_row   = i_row;
            end
            if (live && (i_row.id == i_ctx.cid) && !r_res.match_found) begin
                n_res.match_found = 1'b1;
                n_res.match_idx   = i_stage_idx;
            end
            if (!i_row_valid && !r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_stage_idx;
            end
            if (clr_hit) begin
                n_res.clr_count = r_res.clr_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res          <= '0;
            r_res.best_ask <= NO_ASK;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res     = r_res;
    assign o_clr_hit = clr_hit;
endmodule
`default_nettype wire

// File: rtl/limit_order_book_matcher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// price-time priority order book over a store of 64 resting order slots
// request channel: a beat is taken at a rising edge with start high and
// busy low; the fields are sampled on that edge; busy drops in the cycle
// that carries the last result beat, so the next request can be taken there
// result channel: each result beat sits on the o_ ports for one cycle with
// o_strobe high; the receiver cannot stall, nothing is held back
// the fee register is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this
// every request runs passes over all slots through a single scan unit
// (one slot per cycle, registered memory read), which finds best bid/ask,
// the best eligible opposite order, a free slot, an id match or the orders
// of the agent to clear; each pass is followed by the decide state
// a rejected add, failed cancel, clear or market with nothing to fill answers
// after its first pass; a good add or cancel, and the first trade of a market,
// after a second pass; each further trade beat follows one more pass
// reset empties the book, zeroes the id counter and the fee register;
// slot contents are never cleared, only their valid bits
module limit_order_book_matcher_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic                        i_is_buy,
    input  wire logic [lob_pkg::PRICE_W-1:0] i_limit_price,
    input  wire logic [lob_pkg::AGENT_W-1:0] i_agent,
    input  wire logic [lob_pkg::QTY_W-1:0]   i_quantity,
    input  wire logic [lob_pkg::ID_W-1:0]    i_cancel_id,
    input  wire logic                        i_cfg_we,
    input  wire logic [lob_pkg::FEE_W-1:0]   i_cfg_wdata,
    output logic                             o_strobe,
    output logic [1:0]                       o_status,
    output logic [lob_pkg::ID_W-1:0]         o_new_id,
    output logic                             o_is_trade,
    output logic [lob_pkg::AGENT_W-1:0]      o_buyer_agent,
    output logic [lob_pkg::AGENT_W-1:0]      o_seller_agent,
    output logic [lob_pkg::PRICE_W-1:0]      o_trade_price,
    output logic [lob_pkg::QTY_W-1:0]        o_trade_qty,
    output logic [lob_pkg::QTY_W-1:0]        o_unfilled_qty,
    output logic [lob_pkg::FEE_TOT_W-1:0]    o_fee_total,
    output logic [lob_pkg::PRICE_W-1:0]      o_best_bid,
    output logic [lob_pkg::PRICE_W-1:0]      o_best_ask,
    output logic                             o_last
);
    import lob_pkg::*;

    // control
    t_state             r_state, n_state;
    logic               r_phase, n_phase;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_stage_v, n_stage_v;
    logic [IDX_W-1:0]   r_stage_idx;
    logic [CNT_W-1:0]   r_ntr, n_ntr;
    logic [ID_W-1:0]    r_id_ctr, n_id_ctr;
    logic [FEE_W-1:0]   r_fee;
    logic               scan_init;

    // request context
    t_req               r_req, n_req;
    logic               r_buy, n_buy;
    logic [PRICE_W-1:0] r_price, n_price;
    logic [AGENT_W-1:0] r_agent, n_agent;
    logic [QTY_W-1:0]   r_need, n_need;
    logic [ID_W-1:0]    r_cid, n_cid;
    logic [ID_W-1:0]    r_new_id, n_new_id;

    // last trade applied
    logic [AGENT_W-1:0] r_t_buyer, n_t_buyer;
    logic [AGENT_W-1:0] r_t_seller, n_t_seller;
    logic [PRICE_W-1:0] r_t_price, n_t_price;
    logic [QTY_W-1:0]   r_t_qty, n_t_qty;

    // result beat
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [ID_W-1:0]    r_o_new_id, n_o_new_id;
    logic               r_is_trade, n_is_trade;
    logic [AGENT_W-1:0] r_buyer, n_buyer;
    logic [AGENT_W-1:0] r_seller, n_seller;
    logic [PRICE_W-1:0] r_tr_price, n_tr_price;
    logic [QTY_W-1:0]   r_tr_qty, n_tr_qty;
    logic [QTY_W-1:0]   r_unfilled, n_unfilled;
    logic [FEE_TOT_W-1:0] r_fee_tot, n_fee_tot;
    logic [PRICE_W-1:0] r_bb, n_bb;
    logic [PRICE_W-1:0] r_ba, n_ba;
    logic               r_last, n_last;

    // store and scan hookup
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_row               wr_row;
    logic               inv_en;
    logic [IDX_W-1:0]   inv_addr;
    t_row               rd_row;
    logic               rd_valid;
    t_scan_ctx          ctx;
    t_scan_res          res;
    logic               clr_hit;

    // decide-time helpers
    logic [QTY_W-1:0]        tq;
    logic                    mkt_last;
    logic [CNT_W+FEE_W-1:0]  fee_prod;

    lob_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_idx[IDX_W-1:0]),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_row   (wr_row),
        .i_inv_en   (inv_en),
        .i_inv_addr (inv_addr),
        .o_rd_row   (rd_row),
        .o_rd_valid (rd_valid)
    );

    always_comb begin
        ctx.is_buy = r_buy;
        ctx.agent  = r_agent;
        ctx.cid    = r_cid;
        ctx.clr_en = (r_req == REQ_CLEAR) && !r_phase;
    end

    lob_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (scan_init),
        .i_stage_v   (r_stage_v),
        .i_stage_idx (r_stage_idx),
        .i_row       (rd_row),
        .i_row_valid (rd_valid),
        .i_ctx       (ctx),
        .o_res       (res),
        .o_clr_hit   (clr_hit)
    );

    always_comb begin
        tq       = (res.pick_row.qty < r_need) ? res.pick_row.qty : r_need;
        mkt_last = (r_need == '0) || !res.pick_found || (r_ntr == CNT_W'(MAX_ORDERS));
        fee_prod = res.clr_count * r_fee;
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_stage_v  = 1'b0;
        n_ntr      = r_ntr;
        n_id_ctr   = r_id_ctr;
        n_req      = r_req;
        n_buy      = r_buy;
        n_price    = r_price;
        n_agent    = r_agent;
        n_need     = r_need;
        n_cid      = r_cid;
        n_new_id   = r_new_id;
        n_t_buyer  = r_t_buyer;
        n_t_seller = r_t_seller;
        n_t_price  = r_t_price;
        n_t_qty    = r_t_qty;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_o_new_id = r_o_new_id;
        n_is_trade = r_is_trade;
        n_buyer    = r_buyer;
        n_seller   = r_seller;
        n_tr_price = r_tr_price;
        n_tr_qty   = r_tr_qty;
        n_unfilled = r_unfilled;
        n_fee_tot  = r_fee_tot;
        n_bb       = r_bb;
        n_ba       = r_ba;
        n_last     = r_last;
        scan_init  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = res.pick_idx;
        wr_row     = res.pick_row;
        inv_en     = clr_hit;
        inv_addr   = r_stage_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = t_req'(i_req_type);
                    n_buy     = i_is_buy;
                    n_price   = (i_limit_price > PRICE_TOP) ? PRICE_TOP : i_limit_price;
                    n_agent   = i_agent;
                    n_need    = i_quantity;
                    n_cid     = i_cancel_id;
                    n_phase   = 1'b0;
                    n_ntr     = '0;
                    n_idx     = '0;
                    scan_init = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle, the scan unit sees it in the next cycle
                if (r_idx < CNT_W'(MAX_ORDERS)) begin
                    n_stage_v = 1'b1;
                    n_idx     = r_idx + CNT_W'(1);
                end
                if (r_stage_v && (r_stage_idx == IDX_W'(MAX_ORDERS - 1))) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // default beat: plain non-trade result with current book tops
                n_status   = ST_OK;
                n_o_new_id = '0;
                n_is_trade = 1'b0;
                n_buyer    = '0;
                n_seller   = '0;
                n_tr_price = '0;
                n_tr_qty   = '0;
                n_unfilled = '0;
                n_fee_tot  = '0;
                n_bb       = res.best_bid;
                n_ba       = res.best_ask;
                n_last     = 1'b1;
                n_state    = S_IDLE;
                n_strobe   = 1'b1;
                case (r_req)
                    REQ_ADD: begin
                        if (r_phase) begin
                            n_o_new_id = r_new_id;
                        end else if (r_id_ctr == ID_END) begin
                            n_status = ST_IDS_OUT;
                        end else if (!res.free_found) begin
                            n_status = ST_FULL;
                        end else begin
                            n_strobe     = 1'b0;
                            wr_en        = 1'b1;
                            wr_addr      = res.free_idx;
                            wr_row.side  = r_buy;
                            wr_row.price = r_price;
                            wr_row.agent = r_agent;
                            wr_row.qty   = r_need;
                            wr_row.id    = r_id_ctr;
                            n_new_id     = r_id_ctr;
                            n_id_ctr     = r_id_ctr + ID_W'(1);
                            n_phase      = 1'b1;
                            n_idx        = '0;
                            scan_init    = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                    REQ_MARKET: begin
                        if (!r_phase && ((r_need == '0) || !res.pick_found)) begin
                            n_unfilled = r_need;
                        end else begin
                            if (r_phase) begin
                                n_is_trade = 1'b1;
                                n_buyer    = r_t_buyer;
                                n_seller   = r_t_seller;
                                n_tr_price = r_t_price;
                                n_tr_qty   = r_t_qty;
                                n_unfilled = r_need;
                                n_last     = mkt_last;
                            end else begin
                                n_strobe   = 1'b0;
                            end
                            if (!r_phase || !mkt_last) begin
                                // take the picked order against what is left
                                wr_en      = 1'b1;
                                wr_addr    = res.pick_idx;
                                wr_row.qty = res.pick_row.qty - tq;
                                inv_en     = (res.pick_row.qty == tq);
                                inv_addr   = res.pick_idx;
                                n_need     = r_need - tq;
                                n_t_buyer  = r_buy ? r_agent : res.pick_row.agent;
                                n_t_seller = r_buy ? res.pick_row.agent : r_agent;
                                n_t_price  = res.pick_row.price;
                                n_t_qty    = tq;
                                n_ntr      = r_ntr + CNT_W'(1);
                                n_phase    = 1'b1;
                                n_idx      = '0;
                                scan_init  = 1'b1;
                                n_state    = S_SCAN;
                            end
                        end
                    end
                    REQ_CANCEL: begin
                        if (r_phase) begin
                            n_status = ST_OK;
                        end else if (!res.match_found) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_strobe  = 1'b0;
                            inv_en    = 1'b1;
                            inv_addr  = res.match_idx;
                            n_phase   = 1'b1;
                            n_idx     = '0;
                            scan_init = 1'b1;
                            n_state   = S_SCAN;
                        end
                    end
                    REQ_CLEAR: begin
                        // matching orders were dropped during the pass
                        n_fee_tot = fee_prod[FEE_TOT_W-1:0];
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= 1'b0;
            r_idx     <= '0;
            r_stage_v <= 1'b0;
            r_ntr     <= '0;
            r_id_ctr  <= '0;
            r_fee     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_stage_v <= n_stage_v;
            r_ntr     <= n_ntr;
            r_id_ctr  <= n_id_ctr;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_fee <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage_idx <= r_idx[IDX_W-1:0];
        r_req       <= n_req;
        r_buy       <= n_buy;
        r_price     <= n_price;
        r_agent     <= n_agent;
        r_need      <= n_need;
        r_cid       <= n_cid;
        r_new_id    <= n_new_id;
        r_t_buyer   <= n_t_buyer;
        r_t_seller  <= n_t_seller;
        r_t_price   <= n_t_price;
        r_t_qty     <= n_t_qty;
        r_status    <= n_status;
        r_o_new_id  <= n_o_new_id;
        r_is_trade  <= n_is_trade;
        r_buyer     <= n_buyer;
        r_seller    <= n_seller;
        r_tr_price  <= n_tr_price;
        r_tr_qty    <= n_tr_qty;
        r_unfilled  <= n_unfilled;
        r_fee_tot   <= n_fee_tot;
        r_bb        <= n_bb;
        r_ba        <= n_ba;
        r_last      <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_new_id       = r_o_new_id;
    assign o_is_trade     = r_is_trade;
    assign o_buyer_agent  = r_buyer;
    assign o_seller_agent = r_seller;
    assign o_trade_price  = r_tr_price;
    assign o_trade_qty    = r_tr_qty;
    assign o_unfilled_qty = r_unfilled;
    assign o_fee_total    = r_fee_tot;
    assign o_best_bid     = r_bb;
    assign o_best_ask     = r_ba;
    assign o_last         = r_last;
endmodule
`default_nettype wire

// File: tb/tb_limit_order_book_matcher_top.sv
`timescale 1ns / 1ps

import lob_pkg::*;

// one result beat as it appears on the o_ ports
typedef struct {
    logic [1:0]           status;
    logic [ID_W-1:0]      new_id;
    logic                 is_trade;
    logic [AGENT_W-1:0]   buyer_agent;
    logic [AGENT_W-1:0]   seller_agent;
    logic [PRICE_W-1:0]   trade_price;
    logic [QTY_W-1:0]     trade_qty;
    logic [QTY_W-1:0]     unfilled_qty;
    logic [FEE_TOT_W-1:0] fee_total;
    logic [PRICE_W-1:0]   best_bid;
    logic [PRICE_W-1:0]   best_ask;
    logic                 last;
} t_book_result;

// shadow book: predicts result beats for each accepted request, checks them in order
class book_scoreboard;
    bit                 live[MAX_ORDERS];
    bit                 bid_side[MAX_ORDERS];
    logic [PRICE_W-1:0] level[MAX_ORDERS];
    logic [AGENT_W-1:0] owner[MAX_ORDERS];
    logic [QTY_W-1:0]   size_left[MAX_ORDERS];
    logic [ID_W-1:0]    ord_id[MAX_ORDERS];
    logic [ID_W-1:0]    next_id;
    logic [FEE_W-1:0]   fee;
    t_book_result       pending_q[$];
    int                 errors;
    int                 trades;
    int                 full_rejects;
    int                 beats_seen;

    function new();
        foreach (live[i]) live[i] = 0;
        next_id = '0;
        fee = '0;
        errors = 0;
        trades = 0;
        full_rejects = 0;
        beats_seen = 0;
    endfunction

    function logic [PRICE_W-1:0] top_bid();
        logic [PRICE_W-1:0] b;
        b = '0;
        foreach (live[i])
            if (live[i] && bid_side[i] && level[i] > b) b = level[i];
        return b;
    endfunction

    function logic [PRICE_W-1:0] top_ask();
        logic [PRICE_W-1:0] a;
        a = NO_ASK;
        foreach (live[i])
            if (live[i] && !bid_side[i] && level[i] < a) a = level[i];
        return a;
    endfunction

    // best opposite order not owned by the taker, oldest first within a level
    function int best_maker(bit buy, logic [AGENT_W-1:0] ag);
        int b;
        b = -1;
        foreach (live[i]) begin
            if (!live[i] || owner[i] == ag || bid_side[i] == buy) continue;
            if (b < 0) begin
                b = i;
            end else if (level[i] != level[b]) begin
                if (buy ? level[i] < level[b] : level[i] > level[b]) b = i;
            end else if (ord_id[i] < ord_id[b]) begin
                b = i;
            end
        end
        return b;
    endfunction

    function void push(logic [1:0] st, logic [ID_W-1:0] nid, logic tr,
                       logic [AGENT_W-1:0] buyer, logic [AGENT_W-1:0] seller,
                       logic [PRICE_W-1:0] px, logic [QTY_W-1:0] tq,
                       logic [QTY_W-1:0] unf, logic [FEE_TOT_W-1:0] f, logic lst);
        t_book_result r;
        r.status = st;
        r.new_id = nid;
        r.is_trade = tr;
        r.buyer_agent = buyer;
        r.seller_agent = seller;
        r.trade_price = px;
        r.trade_qty = tq;
        r.unfilled_qty = unf;
        r.fee_total = f;
        r.best_bid = top_bid();
        r.best_ask = top_ask();
        r.last = lst;
        pending_q = {pending_q, r};
    endfunction

    function void note_request(t_req req, bit buy, logic [PRICE_W-1:0] px_in,
                               logic [AGENT_W-1:0] ag, logic [QTY_W-1:0] qty,
                               logic [ID_W-1:0] cid);
        logic [PRICE_W-1:0] px;
        logic [QTY_W-1:0]   need;
        logic [QTY_W-1:0]   tq;
        int                 s;
        int                 n;
        int                 slot;
        int                 cnt;
        bit                 done;
        px = (px_in > PRICE_TOP) ? PRICE_TOP : px_in;
        case (req)
            REQ_ADD: begin
                slot = -1;
                foreach (live[i]) if (!live[i] && slot < 0) slot = i;
                if (next_id == ID_END) begin
                    push(ST_IDS_OUT, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end else if (slot < 0) begin
                    full_rejects++;
                    push(ST_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end else begin
                    live[slot] = 1;
                    bid_side[slot] = buy;
                    level[slot] = px;
                    owner[slot] = ag;
                    size_left[slot] = qty;
                    ord_id[slot] = next_id;
                    push(ST_OK, next_id, 0, 0, 0, 0, 0, 0, 0, 1);
                    next_id++;
                end
            end
            REQ_MARKET: begin
                need = qty;
                n = 0;
                while (need > 0 && n < MAX_ORDERS) begin
                    s = best_maker(buy, ag);
                    if (s < 0) break;
                    tq = (size_left[s] < need) ? size_left[s] : need;
                    need -= tq;
                    size_left[s] -= tq;
                    if (size_left[s] == 0) live[s] = 0;
                    done = (need == 0) || (best_maker(buy, ag) < 0) || (n + 1 >= MAX_ORDERS);
                    push(ST_OK, 0, 1, buy ? ag : owner[s], buy ? owner[s] : ag,
                         level[s], tq, need, 0, done);
                    n++;
                    if (done) return;
                end
                push(ST_OK, 0, 0, 0, 0, 0, 0, need, 0, 1);
            end
            REQ_CANCEL: begin
                slot = -1;
                foreach (live[i]) if (live[i] && ord_id[i] == cid && slot < 0) slot = i;
                if (slot >= 0) begin
                    live[slot] = 0;
                    push(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end else begin
                    push(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0, 1);
                end
            end
            default: begin
                cnt = 0;
                foreach (live[i])
                    if (live[i] && owner[i] == ag) begin
                        live[i] = 0;
                        cnt++;
                    end
                push(ST_OK, 0, 0, 0, 0, 0, 0, 0, FEE_TOT_W'(cnt * fee), 1);
            end
        endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on beat %0d: %s got %h expected %h", beats_seen, what, got, want);
    endtask

    task cmp(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report(what, got, want);
    endtask

    task check_result(t_book_result got);
        t_book_result w;
        beats_seen++;
        if (pending_q.size() == 0) begin
            report("unexpected beat", 0, 0);
            return;
        end
        w = pending_q.pop_front();
        if (got.is_trade === 1'b1) trades++;
        cmp("status", 32'(got.status), 32'(w.status));
        cmp("new id", got.new_id, w.new_id);
        cmp("is_trade", 32'(got.is_trade), 32'(w.is_trade));
        cmp("buyer_agent", 32'(got.buyer_agent), 32'(w.buyer_agent));
        cmp("seller_agent", 32'(got.seller_agent), 32'(w.seller_agent));
        cmp("trade_price", 32'(got.trade_price), 32'(w.trade_price));
        cmp("trade_qty", got.trade_qty, w.trade_qty);
        cmp("unfilled_qty", got.unfilled_qty, w.unfilled_qty);
        cmp("fee_total", 32'(got.fee_total), 32'(w.fee_total));
        cmp("best_bid", 32'(got.best_bid), 32'(w.best_bid));
        cmp("best_ask", 32'(got.best_ask), 32'(w.best_ask));
        cmp("last", 32'(got.last), 32'(w.last));
    endtask
endclass

module tb_limit_order_book_matcher_top;
    // one trade takes about one store pass, so a deep sweep costs a pass per trade
    localparam int PASS_CYCLES = MAX_ORDERS + 16;
    localparam int CYCLE_LIMIT = 3000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type = '0;
    logic                 i_is_buy = 1'b0;
    logic [PRICE_W-1:0]   i_limit_price = '0;
    logic [AGENT_W-1:0]   i_agent = '0;
    logic [QTY_W-1:0]     i_quantity = '0;
    logic [ID_W-1:0]      i_cancel_id = '0;
    logic                 i_cfg_we = 1'b0;
    logic [FEE_W-1:0]     i_cfg_wdata = '0;
    logic                 o_strobe;
    logic [1:0]           o_status;
    logic [ID_W-1:0]      o_new_id;
    logic                 o_is_trade;
    logic [AGENT_W-1:0]   o_buyer_agent;
    logic [AGENT_W-1:0]   o_seller_agent;
    logic [PRICE_W-1:0]   o_trade_price;
    logic [QTY_W-1:0]     o_trade_qty;
    logic [QTY_W-1:0]     o_unfilled_qty;
    logic [FEE_TOT_W-1:0] o_fee_total;
    logic [PRICE_W-1:0]   o_best_bid;
    logic [PRICE_W-1:0]   o_best_ask;
    logic                 o_last;

    book_scoreboard book = new();
    bit             idle_on = 1'b1;
    int             cycles = 0;
    int             requests = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    limit_order_book_matcher_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_is_buy       (i_is_buy),
        .i_limit_price  (i_limit_price),
        .i_agent        (i_agent),
        .i_quantity     (i_quantity),
        .i_cancel_id    (i_cancel_id),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_new_id       (o_new_id),
        .o_is_trade     (o_is_trade),
        .o_buyer_agent  (o_buyer_agent),
        .o_seller_agent (o_seller_agent),
        .o_trade_price  (o_trade_price),
        .o_trade_qty    (o_trade_qty),
        .o_unfilled_qty (o_unfilled_qty),
        .o_fee_total    (o_fee_total),
        .o_best_bid     (o_best_bid),
        .o_best_ask     (o_best_ask),
        .o_last         (o_last)
    );

    // result monitor: outputs read at the edge see the values of the cycle that ends
    always @(posedge i_clk) begin
        t_book_result got;
        if (i_rst_n && o_strobe === 1'b1) begin
            got.status = o_status;
            got.new_id = o_new_id;
            got.is_trade = o_is_trade;
            got.buyer_agent = o_buyer_agent;
            got.seller_agent = o_seller_agent;
            got.trade_price = o_trade_price;
            got.trade_qty = o_trade_qty;
            got.unfilled_qty = o_unfilled_qty;
            got.fee_total = o_fee_total;
            got.best_bid = o_best_bid;
            got.best_ask = o_best_ask;
            got.last = o_last;
            book.check_result(got);
        end
    end

    // watchdog on a hung request or a lost result
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, book.pending_q.size());
            $display("tb_limit_order_book_matcher_top NOT OK");
            $finish;
        end
    end

    // one request beat; start stays high across back-to-back beats
    task send_request(t_req req, bit buy, logic [PRICE_W-1:0] px, logic [AGENT_W-1:0] ag,
                      logic [QTY_W-1:0] qty, logic [ID_W-1:0] cid);
        int gap;
        if (idle_on && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_is_buy <= buy;
        i_limit_price <= px;
        i_agent <= ag;
        i_quantity <= qty;
        i_cancel_id <= cid;
        // busy read at the edge is its pre-edge value, so this is the accepting edge
        do @(posedge i_clk); while (busy);
        book.note_request(req, buy, px, ag, qty, cid);
        requests++;
    endtask

    // lower start, let every expected beat arrive, then cover a trailing pass
    task drain_book;
        start <= 1'b0;
        @(posedge i_clk);
        while (book.pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (2 * PASS_CYCLES) @(posedge i_clk);
    endtask

    task write_fee(logic [FEE_W-1:0] v);
        drain_book();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        book.fee = v;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= FEE_W'($urandom);
        @(posedge i_clk);
    endtask

    // random request, mostly a dense book around a few levels so markets trade
    task random_request;
        int                 pick;
        logic [AGENT_W-1:0] ag;
        logic [PRICE_W-1:0] px;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    cid;
        pick = $urandom_range(99);
        ag = ($urandom_range(9) < 8) ? AGENT_W'($urandom_range(3)) : AGENT_W'($urandom);
        px = ($urandom_range(9) < 8) ? PRICE_W'($urandom_range(95, 110)) : PRICE_W'($urandom);
        qty = ($urandom_range(9) < 8) ? QTY_W'($urandom_range(0, 30)) : QTY_W'($urandom);
        if (book.next_id != 0 && $urandom_range(9) < 8)
            cid = book.next_id - 1 - $urandom_range(0, 10);
        else
            cid = $urandom;
        if (pick < 48)
            send_request(REQ_ADD, 1'($urandom_range(1)), px, ag, qty, $urandom);
        else if (pick < 74)
            send_request(REQ_MARKET, 1'($urandom_range(1)), PRICE_W'($urandom), ag,
                         ($urandom_range(9) < 8) ? QTY_W'($urandom_range(1, 60)) : qty,
                         $urandom);
        else if (pick < 90)
            send_request(REQ_CANCEL, 1'($urandom_range(1)), PRICE_W'($urandom), ag,
                         $urandom, cid);
        else
            send_request(REQ_CLEAR, 1'($urandom_range(1)), PRICE_W'($urandom), ag,
                         $urandom, $urandom);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fee at its top: a clear of many orders reaches the widest fee_total
        write_fee(16'hFFFF);

        // empty book: market with nothing to fill, zero-size market, unknown cancel,
        // clear with no orders
        send_request(REQ_MARKET, 1'b1, '0, 8'd1, 32'd50, '0);
        send_request(REQ_MARKET, 1'b0, '0, 8'd1, 32'd0, '0);
        send_request(REQ_CANCEL, 1'b0, '0, 8'd0, '0, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 1'b1, '0, 8'd255, '0, '0);

        // price saturation, lowest price, zero-size and full-size resting orders
        send_request(REQ_ADD, 1'b0, '1, 8'd255, 32'hFFFF_FFFF, '0);
        send_request(REQ_ADD, 1'b1, '0, 8'd0, 32'd10, '0);
        send_request(REQ_ADD, 1'b0, PRICE_W'(100), 8'd2, 32'd0, '0);
        send_request(REQ_ADD, 1'b0, PRICE_W'(100), 8'd3, 32'd5, '0);
        send_request(REQ_ADD, 1'b0, PRICE_W'(101), 8'd2, 32'd7, '0);
        send_request(REQ_ADD, 1'b1, PRICE_W'(99), 8'd3, 32'd4, '0);
        // agent 2 buys: own asks at the best level skipped, then worse levels
        send_request(REQ_MARKET, 1'b1, '0, 8'd2, 32'd9, '0);
        // sweep through the zero-size ask and the saturated level
        send_request(REQ_MARKET, 1'b1, '0, 8'd4, 32'hFFFF_FFFF, '0);
        // sell into bids, then cancel a live id and a filled one
        send_request(REQ_MARKET, 1'b0, '0, 8'd5, 32'd6, '0);
        send_request(REQ_CANCEL, 1'b0, '0, 8'd0, '0, 32'd1);
        send_request(REQ_CANCEL, 1'b0, '0, 8'd0, '0, 32'd3);
        send_request(REQ_CLEAR, 1'b0, '0, 8'd3, '0, '0);

        // fill all slots, then adds to a full book; two agents own all but one order
        for (int k = 0; k < MAX_ORDERS + 2; k++)
            send_request(REQ_ADD, k[0], PRICE_W'($urandom_range(90, 120)),
                         AGENT_W'(8 + k[0]), QTY_W'($urandom_range(1, 9)), '0);
        // one buyer sweeps every resting ask
        send_request(REQ_MARKET, 1'b1, '0, 8'd200, 32'hFFFF_FFFF, '0);
        send_request(REQ_CLEAR, 1'b0, '0, 8'd9, '0, '0);
        send_request(REQ_CLEAR, 1'b0, '0, 8'd8, '0, '0);

        // fee at zero for the first random stretch
        write_fee(16'h0000);
        for (int k = 0; k < 30; k++) random_request();

        // random fee, and a stretch with no gaps between requests
        write_fee(FEE_W'($urandom));
        idle_on = 1'b0;
        for (int k = 0; k < 25; k++) random_request();
        idle_on = 1'b1;

        // sender waits until the book has answered everything
        drain_book();
        write_fee(16'h0001);
        for (int k = 0; k < 30; k++) random_request();

        drain_book();
        $display("%0d requests, %0d result beats, %0d trades, %0d book-full rejects",
                 requests, book.beats_seen, book.trades, book.full_rejects);
        $display("fee register written at its extremes and at random values between phases");
        if (book.errors == 0 && book.pending_q.size() == 0) begin
            $display("tb_limit_order_book_matcher_top OK");
        end else begin
            $display("tb_limit_order_book_matcher_top NOT OK");
        end
        $finish;
    end
endmodule
